// ----- src/chm_pkg.sv -----
// Shared types, constants and helpers for the chained hash multimap.
package chm_pkg;

    localparam int KEY_W          = 32;
    localparam int IN_REF_W       = 16;
    localparam int OUT_REF_W      = 16;
    localparam int CNT_W          = 9;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = KEY_W / DIV_RADIX_BITS;

    localparam int BUCKETS_DEF      = 256;
    localparam int BUCKET_DEPTH_DEF = 16;
    localparam int REF_WIDTH_DEF    = 16;

    localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 9'd256;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NOMATCH  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [KEY_W-1:0]    block_number;
        logic [IN_REF_W-1:0] entry_ref;
    } req_word_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_REF_W-1:0] found_ref;
        logic                 last;
    } res_word_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FILL_RD,
        S_DECIDE,
        S_SCAN
    } state_t;

    // One radix-2^DIV_RADIX_BITS step of restoring remainder: shift in the
    // next key bits MSB first, subtract the divisor when it fits.
    function automatic logic [CNT_W-1:0] mod_step(
        input logic [CNT_W-1:0]          r,
        input logic [DIV_RADIX_BITS-1:0] bits,
        input logic [CNT_W-1:0]          d
    );
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] acc;
        int               i;
        acc = r;
        for (i = DIV_RADIX_BITS - 1; i >= 0; i--)
        begin
            t = {acc, bits[i]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            acc = t[CNT_W-1:0];
        end
        return acc;
    endfunction

endpackage

// ----- src/chm_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/chained_hash_multimap.sv -----
// Chained hash multimap top level: hash unit, bucket fill table, slot store and scan.
//
// Keys (block_number) map to bucket key % bucket_count, with a count of zero
// taken as 1 and a count above BUCKETS taken as BUCKETS. An insert appends
// {key, entry_ref} to its bucket and returns one word (inserted, or full when
// the bucket already holds BUCKET_DEPTH items; the item is then dropped).
// A search walks its bucket in insertion order and returns one match word per
// stored equal key, last set on the final one, or a single no-match word.
// Results come out on result/result_strobe for one cycle each; the receiver
// cannot stall them, and at most one word is produced per cycle. One item is
// worked at a time (busy high meanwhile). Per item: the steps of the shared
// remainder unit, four key bits a cycle, then one fill-table read, a decide
// step, and for a search of a non-empty bucket one slot-memory read per stored
// item plus a drain step. After reset the fill table is cleared one bucket per
// cycle, so busy stays high until every bucket is cleared; bucket_count writes
// are taken at any time, but should only change while the block is idle. Items
// already stored stay in their old buckets when bucket_count changes.
module chained_hash_multimap #(
    parameter int BUCKETS      = chm_pkg::BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chm_pkg::BUCKET_DEPTH_DEF,
    parameter int REF_WIDTH    = chm_pkg::REF_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  chm_pkg::req_word_t        req,
    output chm_pkg::res_word_t        result,
    output logic                      result_strobe,
    input  logic                      cfg_we,
    input  logic [chm_pkg::CNT_W-1:0] cfg_wdata
);

    // Widths derived from the parameters.
    localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOTS   = BUCKETS * BUCKET_DEPTH;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W  = chm_pkg::KEY_W + REF_WIDTH;
    localparam int DIV_CW  = $clog2(chm_pkg::DIV_STEPS);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    chm_pkg::state_t                    state_reg, state_next;
    chm_pkg::req_word_t                 req_reg, req_next;
    logic [chm_pkg::KEY_W-1:0]          key_sh_reg, key_sh_next;
    logic [chm_pkg::CNT_W-1:0]          rem_reg, rem_next;
    logic [chm_pkg::CNT_W-1:0]          divisor_reg, divisor_next;
    logic [DIV_CW-1:0]                  div_cnt_reg, div_cnt_next;
    logic [SLOT_AW-1:0]                 base_reg, base_next;
    logic [FILL_W-1:0]                  fill_reg, fill_next;
    logic [FILL_W-1:0]                  rd_idx_reg, rd_idx_next;
    logic                               data_vld_reg, data_vld_next;
    logic                               pend_vld_reg, pend_vld_next;
    logic [chm_pkg::OUT_REF_W-1:0]      pend_ref_reg, pend_ref_next;
    chm_pkg::res_word_t                 res_reg, res_next;
    logic                               res_vld_reg, res_vld_next;
    logic [BW-1:0]                      clr_cnt_reg, clr_cnt_next;
    logic [chm_pkg::CNT_W-1:0]          bucket_count_reg, bucket_count_next;

    // Memory ports
    logic                  fill_we, fill_re;
    logic [BW-1:0]         fill_waddr;
    logic [FILL_W-1:0]     fill_wdata, fill_rdata;
    logic                  slot_we, slot_re;
    logic [SLOT_AW-1:0]    slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]     slot_wdata, slot_rdata;

    logic [chm_pkg::CNT_W-1:0] eff_count;
    logic [BW-1:0]             bucket;
    logic                      clr_done;
    logic                      div_done;
    logic                      key_hit;
    logic [chm_pkg::OUT_REF_W-1:0] slot_ref;

    // Effective modulus: zero reads as one, saturate at BUCKETS.
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            eff_count = chm_pkg::CNT_W'(1);
        end
        else if (32'(bucket_count_reg) > 32'(BUCKETS))
        begin
            eff_count = chm_pkg::CNT_W'(BUCKETS);
        end
        else
        begin
            eff_count = bucket_count_reg;
        end
    end

    // Remainder is below the modulus, so it fits the bucket index.
    assign bucket   = BW'(rem_reg);
    assign clr_done = (clr_cnt_reg == BW'(BUCKETS - 1));
    assign div_done = (div_cnt_reg == DIV_CW'(chm_pkg::DIV_STEPS - 1));
    assign key_hit  = (slot_rdata[SLOT_W-1:REF_WIDTH] == req_reg.block_number);
    assign slot_ref = chm_pkg::OUT_REF_W'(slot_rdata[REF_WIDTH-1:0]);

    // ---------------------------------------------------------------
    // Storage
    // ---------------------------------------------------------------
    // Per-bucket fill counts.
    chm_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (bucket),
        .rdata (fill_rdata)
    );

    // Slots, {key, ref}, bucket-major.
    chm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chm_pkg::S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = chm_pkg::S_DIV;
                end
            end
            chm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = chm_pkg::S_FILL_RD;
                end
            end
            chm_pkg::S_FILL_RD:
            begin
                state_next = chm_pkg::S_DECIDE;
            end
            chm_pkg::S_DECIDE:
            begin
                if (req_reg.cmd == chm_pkg::CMD_INSERT || fill_rdata == '0)
                begin
                    state_next = chm_pkg::S_IDLE;
                end
                else
                begin
                    state_next = chm_pkg::S_SCAN;
                end
            end
            chm_pkg::S_SCAN:
            begin
                // No read in flight means the bucket is exhausted.
                if (!data_vld_reg)
                begin
                    state_next = chm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = chm_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and memory control
    // ---------------------------------------------------------------
    always_comb
    begin
        req_next          = req_reg;
        key_sh_next       = key_sh_reg;
        rem_next          = rem_reg;
        divisor_next      = divisor_reg;
        div_cnt_next      = div_cnt_reg;
        base_next         = base_reg;
        fill_next         = fill_reg;
        rd_idx_next       = rd_idx_reg;
        data_vld_next     = data_vld_reg;
        pend_vld_next     = pend_vld_reg;
        pend_ref_next     = pend_ref_reg;
        res_next          = res_reg;
        res_vld_next      = 1'b0;
        clr_cnt_next      = clr_cnt_reg;
        bucket_count_next = cfg_we ? cfg_wdata : bucket_count_reg;

        fill_we    = 1'b0;
        fill_re    = 1'b0;
        fill_waddr = bucket;
        fill_wdata = '0;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_waddr = base_reg + SLOT_AW'(fill_rdata);
        slot_raddr = base_reg + SLOT_AW'(rd_idx_reg);
        slot_wdata = {req_reg.block_number, REF_WIDTH'(req_reg.entry_ref)};

        case (state_reg)
            chm_pkg::S_CLEAR:
            begin
                fill_we      = 1'b1;
                fill_waddr   = clr_cnt_reg;
                fill_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + BW'(1);
            end
            chm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next     = req;
                    key_sh_next  = req.block_number;
                    rem_next     = '0;
                    divisor_next = eff_count;
                    div_cnt_next = '0;
                end
            end
            chm_pkg::S_DIV:
            begin
                rem_next = chm_pkg::mod_step(
                    rem_reg,
                    key_sh_reg[chm_pkg::KEY_W-1 -: chm_pkg::DIV_RADIX_BITS],
                    divisor_reg);
                key_sh_next  = key_sh_reg << chm_pkg::DIV_RADIX_BITS;
                div_cnt_next = div_cnt_reg + DIV_CW'(1);
            end
            chm_pkg::S_FILL_RD:
            begin
                fill_re   = 1'b1;
                base_next = SLOT_AW'(bucket * BUCKET_DEPTH);
            end
            chm_pkg::S_DECIDE:
            begin
                res_vld_next        = 1'b1;
                res_next.found_ref  = '0;
                res_next.last       = 1'b1;
                if (req_reg.cmd == chm_pkg::CMD_INSERT)
                begin
                    if (fill_rdata >= FILL_W'(BUCKET_DEPTH))
                    begin
                        res_next.status = chm_pkg::ST_FULL;
                    end
                    else
                    begin
                        slot_we         = 1'b1;
                        fill_we         = 1'b1;
                        fill_wdata      = fill_rdata + FILL_W'(1);
                        res_next.status = chm_pkg::ST_INSERTED;
                    end
                end
                else if (fill_rdata == '0)
                begin
                    res_next.status = chm_pkg::ST_NOMATCH;
                end
                else
                begin
                    // Start the walk at slot 0; results come from the scan.
                    res_vld_next  = 1'b0;
                    fill_next     = fill_rdata;
                    slot_re       = 1'b1;
                    slot_raddr    = base_reg;
                    rd_idx_next   = FILL_W'(1);
                    data_vld_next = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            chm_pkg::S_SCAN:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    slot_re       = 1'b1;
                    rd_idx_next   = rd_idx_reg + FILL_W'(1);
                    data_vld_next = 1'b1;
                end
                else
                begin
                    data_vld_next = 1'b0;
                end

                if (data_vld_reg)
                begin
                    // A match is held back one hit so the final one can carry last.
                    if (key_hit)
                    begin
                        if (pend_vld_reg)
                        begin
                            res_vld_next       = 1'b1;
                            res_next.status    = chm_pkg::ST_MATCH;
                            res_next.found_ref = pend_ref_reg;
                            res_next.last      = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_ref_next = slot_ref;
                    end
                end
                else
                begin
                    res_vld_next  = 1'b1;
                    res_next.last = 1'b1;
                    pend_vld_next = 1'b0;
                    if (pend_vld_reg)
                    begin
                        res_next.status    = chm_pkg::ST_MATCH;
                        res_next.found_ref = pend_ref_reg;
                    end
                    else
                    begin
                        res_next.status    = chm_pkg::ST_NOMATCH;
                        res_next.found_ref = '0;
                    end
                end
            end
            default:
            begin
                res_vld_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= chm_pkg::S_CLEAR;
            div_cnt_reg      <= '0;
            data_vld_reg     <= 1'b0;
            pend_vld_reg     <= 1'b0;
            res_vld_reg      <= 1'b0;
            clr_cnt_reg      <= '0;
            bucket_count_reg <= chm_pkg::BUCKET_COUNT_RST;
        end
        else
        begin
            state_reg        <= state_next;
            div_cnt_reg      <= div_cnt_next;
            data_vld_reg     <= data_vld_next;
            pend_vld_reg     <= pend_vld_next;
            res_vld_reg      <= res_vld_next;
            clr_cnt_reg      <= clr_cnt_next;
            bucket_count_reg <= bucket_count_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_sh_reg   <= key_sh_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        base_reg     <= base_next;
        fill_reg     <= fill_next;
        rd_idx_reg   <= rd_idx_next;
        pend_ref_reg <= pend_ref_next;
        res_reg      <= res_next;
    end

    assign busy          = (state_reg != chm_pkg::S_IDLE);
    assign result        = res_reg;
    assign result_strobe = res_vld_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // Words only leave from the decide or scan steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> ($past(state_reg) == chm_pkg::S_DECIDE ||
                         $past(state_reg) == chm_pkg::S_SCAN))
        else $error("result word without a decide or scan step");

    // The word marked last closes the item: nothing follows right behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.last) |=> !res_vld_reg)
        else $error("word emitted after the last one of an item");

    // An insert never pushes a fill count past the bucket depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_we && state_reg == chm_pkg::S_DECIDE) |->
            (fill_wdata <= FILL_W'(BUCKET_DEPTH) && fill_wdata != '0))
        else $error("fill count out of range on insert");

    // The scan never reads past the bucket's fill.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == chm_pkg::S_SCAN |-> rd_idx_reg <= fill_reg)
        else $error("scan index beyond bucket fill");

endmodule

// ----- sim/chained_hash_multimap_tb.sv -----
// Testbench for chained_hash_multimap: directed table, then random phases per bucket count.
module chained_hash_multimap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT        = chm_pkg::BUCKETS_DEF;
    localparam int DEPTH       = chm_pkg::BUCKET_DEPTH_DEF;
    localparam int CNT_W       = chm_pkg::CNT_W;
    localparam int KEY_W       = chm_pkg::KEY_W;
    localparam int IN_REF_W    = chm_pkg::IN_REF_W;
    localparam int OUT_REF_W   = chm_pkg::OUT_REF_W;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 39;
    localparam int DIR_ROWS    = 25;
    // Covers the worst-case item time plus long sender gaps and the post-reset
    // clear many times over across ~260 items.
    localparam int LIMIT       = 200000;
    localparam int PRINT_CAP   = 50;
    localparam int TAIL_CYCLES = 40;

    // Command and status codes
    localparam chm_pkg::cmd_t    OP_INSERT   = chm_pkg::CMD_INSERT;
    localparam chm_pkg::cmd_t    OP_SEARCH   = chm_pkg::CMD_SEARCH;
    localparam chm_pkg::status_t RS_INSERTED = chm_pkg::ST_INSERTED;
    localparam chm_pkg::status_t RS_FULL     = chm_pkg::ST_FULL;
    localparam chm_pkg::status_t RS_MATCH    = chm_pkg::ST_MATCH;
    localparam chm_pkg::status_t RS_NOMATCH  = chm_pkg::ST_NOMATCH;

    // How a directed row gets its expected word
    localparam bit BY_HAND  = 1'b1;
    localparam bit BY_MODEL = 1'b0;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    chm_pkg::req_word_t req;
    chm_pkg::res_word_t result;
    logic               result_strobe;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_wdata;

    chained_hash_multimap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the map: bucket count register, fill per bucket and the
    // slot contents. Slots are only read below the fill count.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]     cnt_shadow;
    int unsigned          fill_shadow [NBKT];
    logic [KEY_W-1:0]     key_shadow  [NBKT][DEPTH];
    logic [OUT_REF_W-1:0] ref_shadow  [NBKT][DEPTH];

    // Words still owed by the block, oldest first
    chm_pkg::res_word_t pending_words [$];

    int errors     = 0;
    int n_items    = 0;
    int n_words    = 0;
    int cycle_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Count of zero behaves as one bucket; anything past the table saturates.
    function automatic int unsigned eff_count(input logic [CNT_W-1:0] c);
        if (c == '0)
            return 1;
        if (c > NBKT)
            return NBKT;
        return c;
    endfunction

    // Applies one command to the shadow map and returns the words it yields.
    function automatic void map_outcome(input chm_pkg::req_word_t w,
                                        ref chm_pkg::res_word_t words[$]);
        int unsigned        bkt;
        int unsigned        fill;
        chm_pkg::res_word_t r;
        bkt  = w.block_number % eff_count(cnt_shadow);
        fill = fill_shadow[bkt];
        words.delete();
        if (w.cmd == OP_INSERT)
        begin
            r.found_ref = '0;
            r.last      = 1'b1;
            if (fill >= DEPTH)
            begin
                r.status = RS_FULL;      // bucket full, item dropped
            end
            else
            begin
                key_shadow[bkt][fill] = w.block_number;
                ref_shadow[bkt][fill] = w.entry_ref;
                fill_shadow[bkt]      = fill + 1;
                r.status              = RS_INSERTED;
            end
            words.push_back(r);
        end
        else
        begin
            // scan in insertion order, one word per equal key
            for (int i = 0; i < fill; i++)
            begin
                if (key_shadow[bkt][i] == w.block_number)
                begin
                    r.status    = RS_MATCH;
                    r.found_ref = ref_shadow[bkt][i];
                    r.last      = 1'b0;
                    words.push_back(r);
                end
            end
            if (words.size() == 0)
            begin
                r.status    = RS_NOMATCH;
                r.found_ref = '0;
                r.last      = 1'b1;
                words.push_back(r);
            end
            else
            begin
                r      = words.pop_back();
                r.last = 1'b1;
                words.push_back(r);
            end
        end
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobed word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_words
        chm_pkg::res_word_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_words.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word status=%0d ref=%h last=%b",
                                        result.status, result.found_ref, result.last));
            end
            else
            begin
                want = pending_words.pop_front();
                n_words++;
                status_seen[want.status]++;
                if (result.status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            result.status, want.status));
                if (result.found_ref !== want.found_ref)
                    flag_mismatch($sformatf("found_ref %h, expected %h",
                                            result.found_ref, want.found_ref));
                if (result.last !== want.last)
                    flag_mismatch($sformatf("last %b, expected %b",
                                            result.last, want.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still owed",
                     cycle_count, pending_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver. Inputs move on the falling edge; a command is taken at the
    // rising edge where start is high and busy is low. The expected words
    // are queued at that edge. A hand-typed word replaces the shadow's
    // output, but the shadow still absorbs the command.
    // ------------------------------------------------------------------
    task automatic send_word(input chm_pkg::req_word_t w, input bit by_hand,
                             input chm_pkg::res_word_t typed);
        chm_pkg::res_word_t words [$];
        @(negedge clk);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        map_outcome(w, words);
        if (by_hand)
        begin
            words.delete();
            words.push_back(typed);
        end
        foreach (words[i])
            pending_words.push_back(words[i]);
        n_items++;
    endtask

    // Random sender idling: per-cycle chance of holding start low.
    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            while ($urandom_range(99) < pct)
                @(negedge clk);
        end
    endtask

    // Drop start and wait until every owed word is in and the block is idle.
    task automatic settle_idle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_bucket_count(input logic [CNT_W-1:0] v);
        settle_idle();
        @(negedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        cnt_shadow  = v;
        @(negedge clk);
        cfg_we     <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table, run at the reset bucket count of 256. Bucket 0 gets
    // filled to its depth with repeated keys so the overflow drop and the
    // multi-match search show up; the full-bucket miss scans all slots.
    // ------------------------------------------------------------------
    typedef struct {
        chm_pkg::cmd_t        cmd;
        logic [KEY_W-1:0]     key;
        logic [IN_REF_W-1:0]  eref;
        bit                   by_hand;
        chm_pkg::status_t     st;
        logic [OUT_REF_W-1:0] fref;
        logic                 lst;
    } dir_row_t;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // empty map: both key extremes miss
        '{OP_SEARCH, 32'h0000_0000, 16'h0000, BY_HAND,  RS_NOMATCH,  16'h0000, 1'b1},
        '{OP_SEARCH, 32'hFFFF_FFFF, 16'hFFFF, BY_HAND,  RS_NOMATCH,  16'h0000, 1'b1},
        '{OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, BY_HAND,  RS_INSERTED, 16'h0000, 1'b1},
        '{OP_INSERT, 32'h0000_0000, 16'h0000, BY_HAND,  RS_INSERTED, 16'h0000, 1'b1},
        // search ignores entry_ref
        '{OP_SEARCH, 32'hFFFF_FFFF, 16'h5A5A, BY_HAND,  RS_MATCH,    16'hFFFF, 1'b1},
        '{OP_SEARCH, 32'h0000_0000, 16'hFFFF, BY_HAND,  RS_MATCH,    16'h0000, 1'b1},
        // fill bucket 0 up to its depth
        '{OP_INSERT, 32'h0000_0100, 16'h0001, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0000, 16'h0002, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'hFFFF_FF00, 16'h0004, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0100, 16'h0008, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0000, 16'h0010, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h8000_0000, 16'h0020, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0100, 16'h0040, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0000, 16'h0080, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'hFFFF_FF00, 16'h0100, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0100, 16'h0200, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0000, 16'h0400, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h1234_5600, 16'h0800, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0100, 16'h1000, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'h0000_0000, 16'h2000, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        '{OP_INSERT, 32'hFFFF_FF00, 16'h4000, BY_MODEL, RS_INSERTED, 16'h0000, 1'b0},
        // bucket 0 now full: drop
        '{OP_INSERT, 32'h0000_0200, 16'h7777, BY_HAND,  RS_FULL,     16'h0000, 1'b1},
        '{OP_SEARCH, 32'h0000_0000, 16'h0000, BY_MODEL, RS_MATCH,    16'h0000, 1'b0},
        '{OP_SEARCH, 32'h0000_0300, 16'h0000, BY_HAND,  RS_NOMATCH,  16'h0000, 1'b1},
        '{OP_SEARCH, 32'hFFFF_FF00, 16'h0000, BY_MODEL, RS_MATCH,    16'h0000, 1'b0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        chm_pkg::req_word_t w;
        chm_pkg::res_word_t typed;
        logic [KEY_W-1:0]   pool [8];
        logic [CNT_W-1:0]   phase_cnt [PHASES];
        int                 phase_pct [PHASES];
        int unsigned        eff;

        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cnt_shadow = chm_pkg::BUCKET_COUNT_RST;
        foreach (fill_shadow[b])
            fill_shadow[b] = 0;

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block clears its fill table after reset with busy high;
        // send_word simply waits that out.
        foreach (dir_tab[i])
        begin
            w.cmd           = dir_tab[i].cmd;
            w.block_number  = dir_tab[i].key;
            w.entry_ref     = dir_tab[i].eref;
            typed.status    = dir_tab[i].st;
            typed.found_ref = dir_tab[i].fref;
            typed.last      = dir_tab[i].lst;
            send_word(w, dir_tab[i].by_hand, typed);
        end

        // Random phases. The count changes with items stored, so old items
        // stay in their old buckets. Small counts late on push most
        // traffic into the already full bucket 0.
        phase_cnt[0] = CNT_W'($urandom_range(2, NBKT - 1));
        phase_cnt[1] = 9'd511;     // saturates to the table size
        phase_cnt[2] = 9'd256;
        phase_cnt[3] = 9'd3;
        phase_cnt[4] = 9'd1;
        phase_cnt[5] = 9'd0;       // treated as one bucket
        phase_pct[0] = 21;
        phase_pct[1] = 21;
        phase_pct[2] = 88;
        phase_pct[3] = 88;
        phase_pct[4] = 0;
        phase_pct[5] = 0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_bucket_count(phase_cnt[p]);
            eff = eff_count(phase_cnt[p]);

            // Key pool: one key known to be stored, a few random ones and
            // several that collide with pool[1] in the same bucket, so
            // searches hit, repeat and buckets run full.
            pool[0] = 32'h0000_0100;
            for (int k = 1; k < 4; k++)
                pool[k] = $urandom();
            for (int k = 4; k < 8; k++)
                pool[k] = pool[1] + KEY_W'((k - 3) * eff);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sender_gap(phase_pct[p]);
                // now and then let the block run dry before the next word
                if ($urandom_range(39) == 0)
                    settle_idle();
                w.cmd          = ($urandom_range(1) == 1) ? OP_SEARCH : OP_INSERT;
                w.block_number = ($urandom_range(9) < 7) ? pool[$urandom_range(7)]
                                                         : KEY_W'($urandom());
                w.entry_ref    = IN_REF_W'($urandom_range(16'hFFFF));
                send_word(w, BY_MODEL, typed);
            end
        end

        settle_idle();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Ran %0d words (%0d from the table) over bucket counts %0d,511,256,3,1,0",
                 n_items, DIR_ROWS, phase_cnt[0]);
        $display("Checked %0d out: %0d inserted, %0d full, %0d matches, %0d misses",
                 n_words, status_seen[RS_INSERTED], status_seen[RS_FULL],
                 status_seen[RS_MATCH], status_seen[RS_NOMATCH]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/chm_pkg.sv
src/chm_ram.sv
src/chained_hash_multimap.sv
sim/chained_hash_multimap_tb.sv
